// ===== rtl/distance_window_filter_macros.svh =====
// ----------------------------------------------------------------------------
// distance_window_filter_macros: assertion helpers
// Short forms for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_WINDOW_FILTER_MACROS_SVH
`define DISTANCE_WINDOW_FILTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge of clk.
`define DWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk.
`define DWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dwf_pkg.sv =====
// ----------------------------------------------------------------------------
// dwf_pkg: shared definitions for the distance window filter
// Field widths, mode and register codes, and the controller/datapath buses.
// ----------------------------------------------------------------------------
package dwf_pkg;

  localparam int SAMPLE_W       = 13;
  localparam int MODE_W         = 2;
  localparam int CFG_W          = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CNT_W          = 5;
  localparam int WINDOW_MAX_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 5'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic shift_en;
    logic div_init;
    logic div_step;
    logic out_load;
  } dwf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  shifts;
    logic              mean_go;
  } dwf_status_t;

endpackage

// ===== rtl/dwf_datapath.sv =====
// ----------------------------------------------------------------------------
// dwf_datapath: sample window, sum, sorter, divider and result register
// Holds the configuration registers and all payload storage of the filter.
// ----------------------------------------------------------------------------
module dwf_datapath #(
  parameter int WINDOW_MAX = dwf_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwf_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [dwf_pkg::SAMPLE_W-1:0]   in_sample,
  input  dwf_pkg::dwf_cmd_t              cmd,
  output dwf_pkg::dwf_status_t           status,
  output logic [dwf_pkg::SAMPLE_W-1:0]   result
);

  localparam int SW     = dwf_pkg::SAMPLE_W;
  localparam int CW     = dwf_pkg::CNT_W;
  localparam int PTR_W  = $clog2(WINDOW_MAX);
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SW + FILL_W;
  localparam int SORT_N = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;
  localparam int CMP_W  = (FILL_W > CW) ? FILL_W : CW;

  logic [dwf_pkg::MODE_W-1:0] mode_r;
  logic [dwf_pkg::CFG_W-1:0]  wsize_r;
  logic [PTR_W-1:0]           wp_r;
  logic [PTR_W-1:0]           rd_ptr_r;
  logic [FILL_W-1:0]          fill_r;
  logic                       rd_valid_r;
  logic [SW-1:0]              rd_data_r;
  logic [SW-1:0]              sample_r;
  logic [SUM_W-1:0]           sum_r;
  logic [CW-1:0]              ins_k_r;
  logic [SW-1:0]              srt_r   [SORT_N];
  logic [SW-1:0]              srt_nxt [SORT_N];
  logic [CW-1:0]              rem_r;
  logic [SUM_W-1:0]           dq_r;
  logic [SW-1:0]              result_r;
  logic [SW-1:0]              win_mem [WINDOW_MAX];

  logic [CW-1:0]    n_eff;
  logic [CW-1:0]    count;
  logic [CW:0]      rem_shift;
  logic [CW:0]      rem_diff;
  logic             rem_ge;
  logic [SW:0]      mid_sum;
  logic [SW-1:0]    median;
  logic [SORT_N-1:0] gt;

  // Window size clamped to 1..SORT_N, the smaller of WINDOW_MAX and 31.
  always_comb begin
    if (wsize_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(wsize_r) > SORT_N) begin
      n_eff = CW'(SORT_N);
    end else begin
      n_eff = wsize_r;
    end
  end

  assign count = (CMP_W'(fill_r) < CMP_W'(n_eff)) ? CW'(fill_r) : n_eff;

  assign status.mode    = mode_r;
  assign status.count   = count;
  assign status.shifts  = (count - CW'(1)) >> 1;
  assign status.mean_go = (CMP_W'(fill_r) >= CMP_W'(n_eff));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= dwf_pkg::MODE_RAW;
      wsize_r <= dwf_pkg::WINDOW_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dwf_pkg::REG_FILTER_MODE: mode_r  <= cfg_wdata[dwf_pkg::MODE_W-1:0];
        dwf_pkg::REG_WINDOW_SIZE: wsize_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Ring buffer: one write at accept, one registered read per rd_en.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_mem[wp_r] <= in_sample;
    end
    if (cmd.rd_en) begin
      rd_data_r <= win_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rd_ptr_r   <= '0;
      fill_r     <= '0;
      rd_valid_r <= 1'b0;
      ins_k_r    <= '0;
    end else begin
      rd_valid_r <= cmd.rd_en;
      if (cmd.accept) begin
        wp_r     <= (wp_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_r + PTR_W'(1);
        rd_ptr_r <= wp_r;
        if (32'(fill_r) < WINDOW_MAX) begin
          fill_r <= fill_r + FILL_W'(1);
        end
        ins_k_r <= '0;
      end else begin
        if (cmd.rd_en) begin
          rd_ptr_r <= (rd_ptr_r == '0) ? PTR_W'(WINDOW_MAX - 1) : rd_ptr_r - PTR_W'(1);
        end
        if (rd_valid_r) begin
          ins_k_r <= ins_k_r + CW'(1);
        end
      end
    end
  end

  // Insertion sorter: each cell compares against the incoming word in parallel.
  always_comb begin
    for (int i = 0; i < SORT_N; i++) begin
      gt[i] = (CW'(i) >= ins_k_r) || (srt_r[i] > rd_data_r);
    end
    for (int i = 0; i < SORT_N; i++) begin
      if (cmd.shift_en) begin
        srt_nxt[i] = (i < SORT_N - 1) ? srt_r[(i < SORT_N - 1) ? i + 1 : i] : srt_r[i];
      end else if (rd_valid_r && gt[i]) begin
        srt_nxt[i] = (i > 0 && gt[(i > 0) ? i - 1 : 0]) ? srt_r[(i > 0) ? i - 1 : 0]
                                                          : rd_data_r;
      end else begin
        srt_nxt[i] = srt_r[i];
      end
    end
  end

  // Restoring divider step, one quotient bit per cycle.
  assign rem_shift = {rem_r, dq_r[SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, n_eff};
  assign rem_ge    = (rem_shift >= {1'b0, n_eff});

  assign mid_sum = {1'b0, srt_r[0]} + {1'b0, srt_r[1]};
  assign median  = count[0] ? srt_r[0] : SW'(mid_sum >> 1);

  always_ff @(posedge clk) begin
    for (int i = 0; i < SORT_N; i++) begin
      srt_r[i] <= srt_nxt[i];
    end
    if (cmd.accept) begin
      sample_r <= in_sample;
      sum_r    <= '0;
    end else if (rd_valid_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      dq_r  <= sum_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
      dq_r  <= {dq_r[SUM_W-2:0], rem_ge};
    end
    if (cmd.out_load) begin
      case (mode_r)
        dwf_pkg::MODE_MEAN:   result_r <= dq_r[SW-1:0];
        dwf_pkg::MODE_MEDIAN: result_r <= median;
        default:              result_r <= sample_r;
      endcase
    end
  end

  assign result = result_r;

endmodule

// ===== rtl/dwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwf_ctrl: sequencing state machine of the distance window filter
// Steps mean/median samples through window read-out, median shift or divide;
// hands raw, median and full-window mean results to the output register.
// ----------------------------------------------------------------------------
module dwf_ctrl #(
  parameter int WINDOW_MAX = dwf_pkg::WINDOW_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dwf_pkg::dwf_status_t status,
  output dwf_pkg::dwf_cmd_t    cmd
);

  localparam int CW    = dwf_pkg::CNT_W;
  localparam int SUM_W = dwf_pkg::SAMPLE_W + $clog2(WINDOW_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_DECIDE,
    ST_SHIFT,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_free   = !out_valid_r || out_ready;

  assign cmd.accept   = in_valid && (state_r == ST_IDLE);
  assign cmd.rd_en    = (state_r == ST_LOAD);
  assign cmd.shift_en = (state_r == ST_SHIFT);
  assign cmd.div_init = (state_r == ST_DECIDE) && (status.mode == dwf_pkg::MODE_MEAN)
                        && status.mean_go;
  assign cmd.div_step = (state_r == ST_DIV);
  assign cmd.out_load = (state_r == ST_FIN) && out_free;

  // A result stays valid until taken; a new one is loaded only into a free slot.
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_valid) begin
            if (status.mode == dwf_pkg::MODE_MEAN || status.mode == dwf_pkg::MODE_MEDIAN) begin
              state_r <= ST_LOAD;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_LOAD: begin
          if (cnt_r == status.count - CW'(1)) begin
            cnt_r   <= '0;
            state_r <= ST_WAIT;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_WAIT: state_r <= ST_DECIDE;
        ST_DECIDE: begin
          if (status.mode == dwf_pkg::MODE_MEAN) begin
            state_r <= status.mean_go ? ST_DIV : ST_IDLE;
          end else if (status.shifts != '0) begin
            state_r <= ST_SHIFT;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_SHIFT: begin
          if (cnt_r == status.shifts - CW'(1)) begin
            cnt_r   <= '0;
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_DIV: begin
          if (cnt_r == CW'(SUM_W - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/distance_window_filter.sv =====
// ----------------------------------------------------------------------------
// distance_window_filter: raw / moving mean / moving median distance filter
// Keeps the most recent distance samples in one shared ring buffer and
// returns the sample, the window mean (once the window is full) or the window median per mode.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_distance_sample (13 bits)
//   out_     output     out_valid / out_ready out_filtered_distance (13 bits)
//   cfg_     input      cfg_wr_en             cfg_index, cfg_wdata (5 bits)
//
// The read-out is bound by the single read port of the window memory, the
// mean by the bit-serial divider (one quotient bit a cycle). Reset is
// synchronous and active low; it empties the window and restores the
// configuration defaults. A stalled result waits in the output register while
// the next input beat is already taken in.
//
// Each accepted sample is written into the ring buffer. The controller then
// reads the most recent samples back one per cycle; each word read feeds the
// running sum and a parallel insertion sorter. For the median, the sorted
// array is shifted down until the middle entry (or the two middle entries)
// sit at the bottom. For the mean, the sum goes through a restoring divider.
//
module distance_window_filter #(
  parameter int WINDOW_MAX = dwf_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dwf_pkg::SAMPLE_W-1:0]  in_distance_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dwf_pkg::SAMPLE_W-1:0]  out_filtered_distance,
  input  logic                          cfg_wr_en,
  input  logic [dwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dwf_pkg::CFG_W-1:0]     cfg_wdata
);

`include "distance_window_filter_macros.svh"

  dwf_pkg::dwf_cmd_t    cmd;
  dwf_pkg::dwf_status_t status;

  // The controller sequences; it never touches payload data.
  dwf_ctrl #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the window, the configuration and the result register.
  dwf_datapath #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_sample(in_distance_sample),
    .cmd      (cmd),
    .status   (status),
    .result   (out_filtered_distance)
  );

  // Every accepted beat moves the controller out of its idle state.
  `DWF_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready after accept")
  // Reads are only issued while the window holds at least one sample.
  `DWF_ASSERT_NOW(a_read_count, cmd.rd_en, status.count != '0, "read from empty window")
  // The sequencing phases never overlap.
  `DWF_ASSERT_NOW(a_phase_excl, 1'b1,
    $onehot0({cmd.accept, cmd.rd_en, cmd.shift_en, cmd.div_step, cmd.out_load}),
    "overlapping datapath commands")

endmodule
